@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, suspended while reset is applied.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Property checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

@@ hw/rtl/i2cmbe_pkg.sv @@
package i2cmbe_pkg;

	localparam logic [7:0] DELAY_RESET = 8'd6;
	localparam logic [7:0] DELAY_MIN   = 8'd1;
	localparam int unsigned BYTE_W     = 8;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_STOP  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// Bus sequencer phases; steps that never wait are folded into their neighbours.
	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_S1   = 5'd2,
		PH_S2   = 5'd3,
		PH_S3   = 5'd4,
		PH_S4   = 5'd5,
		PH_P1   = 5'd7,
		PH_P2   = 5'd8,
		PH_P3   = 5'd9,
		PH_W1   = 5'd11,
		PH_W2   = 5'd12,
		PH_W3   = 5'd13,
		PH_W5   = 5'd15,
		PH_R2   = 5'd18,
		PH_R3   = 5'd19,
		PH_A1   = 5'd21,
		PH_A2   = 5'd22,
		PH_A3   = 5'd23,
		PH_A4   = 5'd24,
		PH_A5   = 5'd25,
		PH_N1   = 5'd27,
		PH_N2   = 5'd28,
		PH_N3   = 5'd29,
		PH_N4   = 5'd30
	} phase_t;

	typedef struct packed {
		logic              cmd_valid;
		logic [1:0]        mode;
		logic [BYTE_W-1:0] tx_byte;
		logic              ack_after_read;
		logic              sda_sample;
	} in_word_t;

	typedef struct packed {
		logic              scl_level;
		logic              sda_drive;
		logic              sda_level;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] rx_byte;
		logic              ack_received;
	} out_word_t;

	// Handshake between the pipeline stages
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;

endpackage

@@ hw/rtl/i2cmbe_in_reg.sv @@
module i2cmbe_in_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  i2cmbe_pkg::in_word_t in_data,
	input  logic                 take,
	output i2cmbe_pkg::stage_ctl_t ctl,
	output i2cmbe_pkg::in_word_t word_s1
);

	logic valid_s1;

	assign ctl.valid   = valid_s1;
	assign ctl.advance = valid_s1 && take;
	assign in_stall    = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_data;
		end
	end

endmodule

@@ hw/rtl/i2cmbe_seq.sv @@
module i2cmbe_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [7:0]            cfg_wr_data,
	input  logic                  step_en,
	input  i2cmbe_pkg::in_word_t  word_s1,
	output i2cmbe_pkg::out_word_t result
);

	i2cmbe_pkg::phase_t phase_q, phase_n;
	logic [3:0] bit_cnt_q, bit_cnt_n, bit_inc;
	logic [7:0] shift_q, shift_n;
	logic [7:0] delay_q, delay_n, delay_dec, unit_dly;
	logic [7:0] delay_ticks_q;
	logic [7:0] rx_q, rx_n;
	logic       ack_choice_q, ack_choice_n;
	logic       scl_q, scl_n, sda_q, sda_n, oe_q, oe_n, ack_q, ack_n;
	logic       done;

	assign unit_dly  = (delay_ticks_q == '0) ? i2cmbe_pkg::DELAY_MIN : delay_ticks_q;
	assign delay_dec = (delay_q != '0) ? delay_q - 8'd1 : '0;
	assign bit_inc   = bit_cnt_q + 4'd1;

	always_comb begin
		phase_n      = phase_q;
		bit_cnt_n    = bit_cnt_q;
		shift_n      = shift_q;
		delay_n      = delay_q;
		rx_n         = rx_q;
		ack_choice_n = ack_choice_q;
		scl_n        = scl_q;
		sda_n        = sda_q;
		oe_n         = oe_q;
		ack_n        = ack_q;
		done         = 1'b0;
		if (phase_q == i2cmbe_pkg::PH_IDLE) begin
			if (word_s1.cmd_valid) begin
				ack_choice_n = word_s1.ack_after_read;
				bit_cnt_n    = '0;
				shift_n      = '0;
				delay_n      = unit_dly;
				case (i2cmbe_pkg::cmd_t'(word_s1.mode))
					i2cmbe_pkg::CMD_START: begin
						oe_n    = 1'b1;
						sda_n   = 1'b1;
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_S1;
					end
					i2cmbe_pkg::CMD_STOP: begin
						oe_n    = 1'b1;
						scl_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_P1;
					end
					i2cmbe_pkg::CMD_WRITE: begin
						shift_n = word_s1.tx_byte;
						scl_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_W1;
					end
					default: begin
						// read: release SDA and drop SCL for the first bit
						oe_n    = 1'b0;
						scl_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_R2;
					end
				endcase
			end
		end else begin
			delay_n = delay_dec;
			if (delay_dec == '0) begin
				delay_n = unit_dly;
				case (phase_q)
					i2cmbe_pkg::PH_S1: phase_n = i2cmbe_pkg::PH_S2;
					i2cmbe_pkg::PH_S2: begin
						sda_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_S3;
					end
					i2cmbe_pkg::PH_S3: phase_n = i2cmbe_pkg::PH_S4;
					i2cmbe_pkg::PH_S4: begin
						scl_n   = 1'b0;
						delay_n = '0;
						phase_n = i2cmbe_pkg::PH_IDLE;
						done    = 1'b1;
					end
					i2cmbe_pkg::PH_P1: begin
						sda_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_P2;
					end
					i2cmbe_pkg::PH_P2: begin
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_P3;
					end
					i2cmbe_pkg::PH_P3: begin
						sda_n   = 1'b1;
						delay_n = '0;
						phase_n = i2cmbe_pkg::PH_IDLE;
						done    = 1'b1;
					end
					i2cmbe_pkg::PH_W1: begin
						oe_n    = 1'b1;
						phase_n = i2cmbe_pkg::PH_W2;
					end
					i2cmbe_pkg::PH_W2: begin
						sda_n   = shift_q[7];
						shift_n = {shift_q[6:0], 1'b0};
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_W3;
					end
					i2cmbe_pkg::PH_W3: begin
						// SCL held high, then straight into the next bit or the ack slot
						bit_cnt_n = bit_inc;
						scl_n     = 1'b1;
						if (!bit_inc[3]) begin
							sda_n   = shift_q[7];
							shift_n = {shift_q[6:0], 1'b0};
							phase_n = i2cmbe_pkg::PH_W3;
						end else begin
							oe_n    = 1'b0;
							phase_n = i2cmbe_pkg::PH_W5;
						end
					end
					i2cmbe_pkg::PH_W5: begin
						ack_n   = !word_s1.sda_sample;
						scl_n   = 1'b0;
						delay_n = '0;
						phase_n = i2cmbe_pkg::PH_IDLE;
						done    = 1'b1;
					end
					i2cmbe_pkg::PH_R2: begin
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_R3;
					end
					i2cmbe_pkg::PH_R3: begin
						shift_n   = {shift_q[6:0], word_s1.sda_sample};
						bit_cnt_n = bit_inc;
						scl_n     = 1'b0;
						if (!bit_inc[3]) begin
							phase_n = i2cmbe_pkg::PH_R2;
						end else if (ack_choice_q) begin
							phase_n = i2cmbe_pkg::PH_A1;
						end else begin
							phase_n = i2cmbe_pkg::PH_N1;
						end
					end
					i2cmbe_pkg::PH_A1: begin
						oe_n    = 1'b1;
						sda_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_A2;
					end
					i2cmbe_pkg::PH_A2: begin
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_A3;
					end
					i2cmbe_pkg::PH_A3: phase_n = i2cmbe_pkg::PH_A4;
					i2cmbe_pkg::PH_A4: begin
						scl_n   = 1'b0;
						phase_n = i2cmbe_pkg::PH_A5;
					end
					i2cmbe_pkg::PH_N1: begin
						oe_n    = 1'b0;
						phase_n = i2cmbe_pkg::PH_N2;
					end
					i2cmbe_pkg::PH_N2: begin
						scl_n   = 1'b1;
						phase_n = i2cmbe_pkg::PH_N3;
					end
					i2cmbe_pkg::PH_N3: phase_n = i2cmbe_pkg::PH_N4;
					i2cmbe_pkg::PH_A5, i2cmbe_pkg::PH_N4: begin
						rx_n    = shift_q;
						delay_n = '0;
						phase_n = i2cmbe_pkg::PH_IDLE;
						done    = 1'b1;
					end
					default: begin
						delay_n = '0;
						phase_n = i2cmbe_pkg::PH_IDLE;
						done    = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		result.scl_level    = scl_n;
		result.sda_drive    = oe_n;
		result.sda_level    = oe_n & sda_n;
		result.busy_res     = (phase_n != i2cmbe_pkg::PH_IDLE);
		result.done_res     = done;
		result.rx_byte      = rx_n;
		result.ack_received = ack_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q <= i2cmbe_pkg::DELAY_RESET;
		end else if (cfg_wr_en) begin
			delay_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cmbe_pkg::PH_IDLE;
			bit_cnt_q    <= '0;
			shift_q      <= '0;
			delay_q      <= '0;
			rx_q         <= '0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			oe_q         <= 1'b0;
			ack_q        <= 1'b0;
		end else if (step_en) begin
			phase_q      <= phase_n;
			bit_cnt_q    <= bit_cnt_n;
			shift_q      <= shift_n;
			delay_q      <= delay_n;
			rx_q         <= rx_n;
			ack_choice_q <= ack_choice_n;
			scl_q        <= scl_n;
			sda_q        <= sda_n;
			oe_q         <= oe_n;
			ack_q        <= ack_n;
		end
	end

endmodule

@@ hw/rtl/i2cmbe_out_reg.sv @@
module i2cmbe_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i2cmbe_pkg::stage_ctl_t ctl,
	input  i2cmbe_pkg::out_word_t  result,
	output logic                   take,
	output logic                   out_valid,
	input  logic                   out_stall,
	output i2cmbe_pkg::out_word_t  out_data
);

	logic valid_q;

	assign take      = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			out_data <= result;
		end
	end

endmodule

@@ hw/rtl/i2c_master_bit_engine_unit.sv @@
// I2C master bit engine.
// Input channel: one word per bus timing tick, carrying an optional command
// (start, stop, write byte, read byte), the byte to send, the ack choice for
// reads and the sampled SDA level. Output channel: one word per input word,
// giving SCL and SDA pin levels, busy, done, the last read byte and the last
// write acknowledge.
// Config: cfg_wr_en/cfg_wr_data set ticks per unit delay (0 acts as 1).
// A taken word passes the input register, then the result register, before
// out_valid. Throughput: one word per clock while the output is not stalled;
// the sequencer state (phase, delay counter, shifter) steps with each word.
// Reset: pins idle (SCL high, SDA released), phase idle, delay 6 ticks,
// both pipeline registers empty.
// Stall: a stalled output word holds; the input register keeps its word and
// raises in_stall, so no tick is lost or repeated.
module i2c_master_bit_engine_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [7:0]            cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  i2cmbe_pkg::in_word_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output i2cmbe_pkg::out_word_t out_data
);

	i2cmbe_pkg::stage_ctl_t ctl;
	i2cmbe_pkg::in_word_t   word_s1;
	i2cmbe_pkg::out_word_t  result;
	logic                   take;

	// input register: holds the tick word until the sequencer consumes it
	i2cmbe_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.take     (take),
		.ctl      (ctl),
		.word_s1  (word_s1)
	);

	// sequencer: state only moves when the word goes on to the result register
	i2cmbe_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step_en     (ctl.advance),
		.word_s1     (word_s1),
		.result      (result)
	);

	// result register, refilled whenever it is empty or being drained
	i2cmbe_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ hw/rtl/i2cmbe_checker.sv @@
`include "assert_macros.svh"

module i2cmbe_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input i2cmbe_pkg::out_word_t out_data
);

	`ASSERT_CLKD(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid)
	`ASSERT_CLKD(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable(out_data))
	`ASSERT_CLKD(a_done_idle, clk, arst_n, out_valid |-> !(out_data.done_res && out_data.busy_res))
	`ASSERT_CLKD(a_sda_rel, clk, arst_n, out_valid && !out_data.sda_drive |-> !out_data.sda_level)
	`ASSERT_CLKD(a_stall_full, clk, arst_n, in_stall |-> out_valid && out_stall)

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
